// ===== hdl/rprt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the reader progress rank tracker.
// No dependencies; every other file in hdl/ uses this package.
package rprt_pkg;

    // Field widths of the command and result beats
    localparam int USER_W  = 17;
    localparam int PAGE_W  = 11;
    localparam int FRAC_W  = 17;

    // Store sizes
    localparam int MAX_USERS = 131072;
    localparam int MAX_PAGES = 1024;
    localparam int USER_AW   = $clog2(MAX_USERS);
    localparam int HIST_AW   = $clog2(MAX_PAGES);

    // The clearing sweep covers the larger of the two stores
    localparam int CLR_DEPTH = (MAX_USERS > MAX_PAGES) ? MAX_USERS : MAX_PAGES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Saturating counters (histogram entries and active-user count)
    localparam int              CNT_W   = 18;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Q1.16 result and the shift-subtract divider behind it
    localparam int               FRAC_SH   = 16;
    localparam int               QUO_W     = FRAC_W + 1;
    localparam int               NUM_W     = CNT_W + FRAC_SH;
    localparam int               STEP_W    = $clog2(QUO_W);
    localparam logic [QUO_W-1:0] Q_ONE     = QUO_W'(1) << FRAC_SH;

    // Command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [USER_W-1:0]  t_user;
    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FRAC_W-1:0]  t_frac;
    typedef logic [CNT_W-1:0]   t_cnt;

endpackage

// ===== hdl/rprt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and rank result beats.
// Depends on rprt_pkg for the payload types.
interface rprt_cmd_if;
    logic            valid;
    logic            ready;
    logic            command;
    rprt_pkg::t_user user_id;
    rprt_pkg::t_page page_count;

    modport source (output valid, output command, output user_id, output page_count,
                    input ready);
    modport sink   (input valid, input command, input user_id, input page_count,
                    output ready);
endinterface

interface rprt_rank_if;
    logic            valid;
    logic            ready;
    rprt_pkg::t_frac rank_fraction;

    modport source (output valid, output rank_fraction, input ready);
    modport sink   (input valid, input rank_fraction, output ready);
endinterface

// ===== hdl/reader_progress_rank_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the reader progress rank tracker: progress and histogram memories,
// the update/query sequencer and a bit-serial divider. Uses rprt_pkg and rprt_if.
//
// Usage
//   i_cmd  : command beats. command selects a progress update or a rank query;
//            user_id names the user; page_count is used by updates only.
//   o_rank : one beat per query carrying rank_fraction (unsigned Q1.16,
//            65536 = 1.0). Updates give no beat.
//   After reset the block sweeps both memories to zero, one entry per cycle;
//   the progress memory sets the length of the sweep. i_cmd.ready is low
//   during the sweep.
//   One command at a time; i_cmd.ready is high only when the sequencer idles.
//   Update: its length grows with the number of histogram entries raised
//   (new - old pages, up to 1024, none when the count does not rise); each
//   histogram entry is read, then written back from its registered read, which sets this.
//   Query: shortest when no histogram read is needed, longer when the histogram
//   count reaches the active count, longest when the 18-step shift-subtract divider runs.
//   The result sits in an output register; a query finishing while that
//   register still holds an untaken beat waits there until the receiver takes
//   it, and later commands wait behind it; otherwise updates ignore the receiver.
module reader_progress_rank_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rprt_cmd_if.sink           i_cmd,
    rprt_rank_if.source        o_rank
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROG,
        ST_HIST,
        ST_HRD,
        ST_DIV,
        ST_OUT
    } t_state;

    // Control and datapath registers
    t_state                         r_state,     n_state;
    logic [rprt_pkg::CLR_W-1:0]     r_clr,       n_clr;
    rprt_pkg::t_cnt                 r_active,    n_active;
    logic                           r_cmd,       n_cmd;
    logic                           r_user_ok,   n_user_ok;
    logic [rprt_pkg::USER_AW-1:0]   r_user,      n_user;
    rprt_pkg::t_page                r_pages,     n_pages;
    rprt_pkg::t_page                r_idx,       n_idx;
    logic                           r_pend,      n_pend;
    logic [rprt_pkg::HIST_AW-1:0]   r_wr_idx,    n_wr_idx;
    rprt_pkg::t_cnt                 r_rem,       n_rem;
    logic [rprt_pkg::QUO_W-1:0]     r_lo,        n_lo;
    logic [rprt_pkg::QUO_W-1:0]     r_quo,       n_quo;
    rprt_pkg::t_cnt                 r_div,       n_div;
    logic [rprt_pkg::STEP_W-1:0]    r_step,      n_step;
    logic                           r_out_valid, n_out_valid;
    rprt_pkg::t_frac                r_out_frac,  n_out_frac;

    // Memory ports
    rprt_pkg::t_page                prog_mem [rprt_pkg::MAX_USERS];
    rprt_pkg::t_cnt                 hist_mem [rprt_pkg::MAX_PAGES];
    logic                           prog_we;
    logic [rprt_pkg::USER_AW-1:0]   prog_wa, prog_ra;
    rprt_pkg::t_page                prog_wd, r_prog_rd;
    logic                           hist_we;
    logic [rprt_pkg::HIST_AW-1:0]   hist_wa, hist_ra;
    rprt_pkg::t_cnt                 hist_wd, r_hist_rd;

    // Combinational helpers
    logic                           in_beat;
    logic                           out_free;
    rprt_pkg::t_page                in_pages_sat;
    rprt_pkg::t_cnt                 diff;
    logic [rprt_pkg::NUM_W-1:0]     num;
    logic [rprt_pkg::CNT_W:0]       rem_sh;
    logic [rprt_pkg::CNT_W:0]       trial;
    rprt_pkg::t_frac                quo_sat;

    assign in_beat  = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_rank.ready;
    assign i_cmd.ready        = (r_state == ST_IDLE);
    assign o_rank.valid         = r_out_valid;
    assign o_rank.rank_fraction = r_out_frac;

    // Page counts above the histogram size saturate
    assign in_pages_sat = (32'(i_cmd.page_count) > rprt_pkg::MAX_PAGES)
                        ? rprt_pkg::PAGE_W'(rprt_pkg::MAX_PAGES) : i_cmd.page_count;

    // Divider: numerator (active - h) << 16, one quotient bit per cycle
    assign diff   = r_active - r_hist_rd;
    assign num    = {diff, rprt_pkg::FRAC_SH'(0)};
    assign rem_sh = {r_rem, r_lo[rprt_pkg::QUO_W-1]};
    assign trial  = rem_sh - {1'b0, r_div};
    assign quo_sat = (r_quo > rprt_pkg::Q_ONE) ? rprt_pkg::FRAC_W'(rprt_pkg::Q_ONE)
                                               : r_quo[rprt_pkg::FRAC_W-1:0];

    // Sequencer next-state and memory controls
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_active    = r_active;
        n_cmd       = r_cmd;
        n_user_ok   = r_user_ok;
        n_user      = r_user;
        n_pages     = r_pages;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_wr_idx    = r_wr_idx;
        n_rem       = r_rem;
        n_lo        = r_lo;
        n_quo       = r_quo;
        n_div       = r_div;
        n_step      = r_step;
        n_out_frac  = r_out_frac;
        n_out_valid = r_out_valid && !o_rank.ready;

        prog_we = 1'b0;
        prog_wa = r_user;
        prog_wd = r_pages;
        prog_ra = rprt_pkg::USER_AW'(i_cmd.user_id);
        hist_we = 1'b0;
        hist_wa = r_wr_idx;
        hist_wd = (r_hist_rd == rprt_pkg::CNT_MAX) ? r_hist_rd : r_hist_rd + 1'b1;
        hist_ra = r_idx[rprt_pkg::HIST_AW-1:0];

        case (r_state)
            ST_CLEAR: begin
                // Zero both memories after reset
                prog_we = (32'(r_clr) < rprt_pkg::MAX_USERS);
                prog_wa = rprt_pkg::USER_AW'(r_clr);
                prog_wd = '0;
                hist_we = (32'(r_clr) < rprt_pkg::MAX_PAGES);
                hist_wa = rprt_pkg::HIST_AW'(r_clr);
                hist_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == rprt_pkg::CLR_W'(rprt_pkg::CLR_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                // Capture the beat; progress read is issued now
                if (in_beat) begin
                    n_cmd     = i_cmd.command;
                    n_user_ok = (32'(i_cmd.user_id) < rprt_pkg::MAX_USERS);
                    n_user    = rprt_pkg::USER_AW'(i_cmd.user_id);
                    n_pages   = in_pages_sat;
                    n_state   = ST_PROG;
                end
            end

            ST_PROG: begin
                if (r_cmd == rprt_pkg::CMD_UPDATE) begin
                    if (!r_user_ok || r_pages == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        prog_we = 1'b1;
                        if (r_prog_rd == '0 && r_active != rprt_pkg::CNT_MAX) begin
                            n_active = r_active + 1'b1;
                        end
                        n_idx  = r_prog_rd;
                        n_pend = 1'b0;
                        n_state = (r_prog_rd < r_pages) ? ST_HIST : ST_IDLE;
                    end
                end else begin
                    if (!r_user_ok || r_prog_rd == '0) begin
                        n_quo   = '0;
                        n_state = ST_OUT;
                    end else if (r_active <= rprt_pkg::CNT_W'(1)) begin
                        n_quo   = (r_active == rprt_pkg::CNT_W'(1)) ? rprt_pkg::Q_ONE : '0;
                        n_state = ST_OUT;
                    end else begin
                        hist_ra = rprt_pkg::HIST_AW'(r_prog_rd - 1'b1);
                        n_state = ST_HRD;
                    end
                end
            end

            ST_HIST: begin
                // Read entry idx, write back entry idx-1 raised by one
                hist_we = r_pend;
                if (r_idx < r_pages) begin
                    n_wr_idx = r_idx[rprt_pkg::HIST_AW-1:0];
                    n_idx    = r_idx + 1'b1;
                    n_pend   = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end
            end

            ST_HRD: begin
                if (r_hist_rd >= r_active) begin
                    n_quo   = '0;
                    n_state = ST_OUT;
                end else begin
                    n_rem   = rprt_pkg::CNT_W'(num[rprt_pkg::NUM_W-1:rprt_pkg::QUO_W]);
                    n_lo    = num[rprt_pkg::QUO_W-1:0];
                    n_quo   = '0;
                    n_div   = r_active - 1'b1;
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end

            ST_DIV: begin
                // One restoring step per cycle
                if (rem_sh >= {1'b0, r_div}) begin
                    n_rem = trial[rprt_pkg::CNT_W-1:0];
                    n_quo = {r_quo[rprt_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[rprt_pkg::CNT_W-1:0];
                    n_quo = {r_quo[rprt_pkg::QUO_W-2:0], 1'b0};
                end
                n_lo   = {r_lo[rprt_pkg::QUO_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == rprt_pkg::STEP_W'(rprt_pkg::QUO_W - 1)) begin
                    n_state = ST_OUT;
                end
            end

            ST_OUT: begin
                // Hand the result to the output register once it is free
                if (out_free) begin
                    n_out_frac  = quo_sat;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_active    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_active    <= n_active;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_user_ok  <= n_user_ok;
        r_user     <= n_user;
        r_pages    <= n_pages;
        r_idx      <= n_idx;
        r_wr_idx   <= n_wr_idx;
        r_rem      <= n_rem;
        r_lo       <= n_lo;
        r_quo      <= n_quo;
        r_div      <= n_div;
        r_step     <= n_step;
        r_out_frac <= n_out_frac;
    end

    // Progress memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (prog_we) begin
            prog_mem[prog_wa] <= prog_wd;
        end
        r_prog_rd <= prog_mem[prog_ra];
    end

    // Histogram memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_wa] <= hist_wd;
        end
        r_hist_rd <= hist_mem[hist_ra];
    end

endmodule

// ===== dv/reader_progress_rank_tracker_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for reader_progress_rank_tracker: a directed table, then random beats,
// each query result compared with an in-bench rank predictor. Needs rprt_pkg, rprt_if, the RTL.
module reader_progress_rank_tracker_test;

    localparam int     CLK_HALF         = 6;
    localparam int     RANDOM_ITEMS     = 560;
    localparam int     POOL_SIZE        = 24;
    localparam int     LONG_HOLD_CYCLES = 400;
    localparam int     HOLD_AT_ITEM     = 150;
    localparam int     DRAIN_AT_ITEM    = 380;
    localparam int     SETTLE_CYCLES    = 1100;   // longest update plus margin
    // Reset sweep plus every beat at its worst, taken about 5x
    localparam longint TIMEOUT_NS       = 64'd48_000_000;
    localparam rprt_pkg::t_frac FRAC_ONE = rprt_pkg::t_frac'(1) << rprt_pkg::FRAC_SH;

    // One row of the directed table; fixed rows carry their rank by hand
    typedef struct packed {
        logic            command;
        rprt_pkg::t_user user;
        rprt_pkg::t_page pages;
        logic            fixed;
        rprt_pkg::t_frac fixed_rank;
    } t_step;

    localparam logic UPD = rprt_pkg::CMD_UPDATE;
    localparam logic QRY = rprt_pkg::CMD_QUERY;

    localparam int    DIRECTED_LEN = 22;
    localparam t_step DIRECTED_STEPS [DIRECTED_LEN] = '{
        '{QRY, 17'd0,      11'd0,    1'b1, 17'd0},      // nobody active yet
        '{QRY, 17'd131071, 11'd0,    1'b1, 17'd0},      // top user id, no progress
        '{UPD, 17'd0,      11'd0,    1'b0, 17'd0},      // zero pages: dropped
        '{QRY, 17'd0,      11'd0,    1'b1, 17'd0},
        '{UPD, 17'd5,      11'd1,    1'b0, 17'd0},      // lowest page count
        '{QRY, 17'd5,      11'd0,    1'b1, FRAC_ONE},   // sole active reader
        '{UPD, 17'd131071, 11'd2047, 1'b0, 17'd0},      // saturates to MAX_PAGES
        '{QRY, 17'd131071, 11'd0,    1'b0, 17'd0},
        '{QRY, 17'd5,      11'd0,    1'b0, 17'd0},
        '{UPD, 17'd7,      11'd1024, 1'b0, 17'd0},      // exactly MAX_PAGES
        '{UPD, 17'd7,      11'd3,    1'b0, 17'd0},      // drop back, histogram kept
        '{UPD, 17'd7,      11'd10,   1'b0, 17'd0},      // rise again, pages recounted
        '{QRY, 17'd7,      11'd0,    1'b0, 17'd0},      // histogram count reaches active count
        '{UPD, 17'h0AAAA,  11'h555,  1'b0, 17'd0},
        '{UPD, 17'h15555,  11'h2AA,  1'b0, 17'd0},
        '{QRY, 17'h15555,  11'h7FF,  1'b0, 17'd0},
        '{QRY, 17'h0AAAA,  11'd0,    1'b0, 17'd0},
        '{UPD, 17'd5,      11'd1,    1'b0, 17'd0},      // same count again
        '{QRY, 17'd5,      11'd0,    1'b0, 17'd0},
        '{QRY, 17'd12345,  11'd0,    1'b1, 17'd0},      // never written
        '{UPD, 17'd1,      11'h3FF,  1'b0, 17'd0},
        '{QRY, 17'd1,      11'd0,    1'b0, 17'd0}
    };

    logic i_clk;
    logic i_rst_n;

    rprt_cmd_if  cmd_if ();
    rprt_rank_if rank_if ();

    reader_progress_rank_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rank  (rank_if)
    );

    // Predictor state; two-state so that every entry starts at zero
    bit [rprt_pkg::PAGE_W-1:0] user_pages   [rprt_pkg::MAX_USERS];
    bit [rprt_pkg::CNT_W-1:0]  pages_passed [rprt_pkg::MAX_PAGES];
    rprt_pkg::t_cnt            active_count;
    rprt_pkg::t_frac           expected_ranks [$];

    rprt_pkg::t_user reader_pool [POOL_SIZE];
    bit    start_long_hold;
    int    mismatches;
    int    updates_sent;
    int    queries_sent;
    int    regressions;
    int    ranks_checked;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input rprt_pkg::t_frac want,
                                   input rprt_pkg::t_frac got);
        $display("%0t MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // Progress update as the block applies it
    task automatic record_progress(input rprt_pkg::t_user user, input rprt_pkg::t_page pages);
        int unsigned old_pages;
        int unsigned new_pages;
        if (pages == 0) return;
        new_pages = (pages > rprt_pkg::MAX_PAGES) ? rprt_pkg::MAX_PAGES : pages;
        old_pages = user_pages[user];
        if (new_pages < old_pages) regressions++;
        if (old_pages == 0 && active_count != rprt_pkg::CNT_MAX) active_count++;
        user_pages[user] = new_pages;
        for (int unsigned i = old_pages; i < new_pages; i++) begin
            if (pages_passed[i] != rprt_pkg::CNT_MAX) pages_passed[i]++;
        end
    endtask

    // Share of the other active readers behind this one, Q1.16 truncated
    function automatic rprt_pkg::t_frac rank_of(input rprt_pkg::t_user user);
        int unsigned     at_page;
        rprt_pkg::t_cnt  reached;
        longint unsigned share;
        at_page = user_pages[user];
        if (at_page == 0) return '0;
        if (active_count <= 1) return (active_count == 1) ? FRAC_ONE : rprt_pkg::t_frac'(0);
        reached = pages_passed[at_page - 1];
        if (reached >= active_count) return '0;
        share = 64'(active_count - reached);
        share = (share << rprt_pkg::FRAC_SH) / 64'(active_count - 1);
        if (share > FRAC_ONE) share = FRAC_ONE;
        return rprt_pkg::t_frac'(share);
    endfunction

    // Present one beat and hold it until taken; the predictor runs on acceptance
    task automatic offer(input logic command, input rprt_pkg::t_user user,
                         input rprt_pkg::t_page pages, input bit fixed,
                         input rprt_pkg::t_frac fixed_rank);
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= command;
        cmd_if.user_id    <= user;
        cmd_if.page_count <= pages;
        @(posedge i_clk);
        while (cmd_if.ready !== 1'b1) @(posedge i_clk);
        if (command == rprt_pkg::CMD_UPDATE) begin
            updates_sent++;
            record_progress(user, pages);
        end else begin
            queries_sent++;
            expected_ranks.push_back(fixed ? fixed_rank : rank_of(user));
        end
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n == 0) return;
        cmd_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_for_ranks();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_ranks.size() != 0) @(posedge i_clk);
    endtask

    // One random beat; mostly tracked readers climbing gradually, some noise
    task automatic random_beat(output bit counts);
        int unsigned     roll;
        int unsigned     sub;
        int unsigned     now_at;
        int unsigned     step;
        rprt_pkg::t_user user;
        rprt_pkg::t_page pages;
        roll   = $urandom_range(0, 99);
        user   = reader_pool[$urandom_range(0, POOL_SIZE - 1)];
        counts = 1'b1;
        if (roll < 45) begin
            now_at = user_pages[user];
            sub    = $urandom_range(0, 99);
            step   = $urandom_range(0, 24);
            if (sub < 3) pages = rprt_pkg::t_page'($urandom_range(1, 2047));
            else if (sub < 6) pages = '0;
            else if (sub < 16 && now_at > 1)
                pages = rprt_pkg::t_page'($urandom_range(1, now_at - 1));
            else if (now_at + step > rprt_pkg::MAX_PAGES)
                pages = rprt_pkg::t_page'($urandom_range(1, 40));
            else pages = rprt_pkg::t_page'(now_at + step);
            counts = (pages != 0);
            offer(rprt_pkg::CMD_UPDATE, user, pages, 1'b0, '0);
        end else if (roll < 85) begin
            offer(rprt_pkg::CMD_QUERY, user, rprt_pkg::t_page'($urandom), 1'b0, '0);
        end else if (roll < 93) begin
            offer(rprt_pkg::CMD_QUERY,
                  rprt_pkg::t_user'($urandom_range(0, rprt_pkg::MAX_USERS - 1)),
                  rprt_pkg::t_page'($urandom), 1'b0, '0);
        end else begin
            offer(rprt_pkg::CMD_UPDATE,
                  rprt_pkg::t_user'($urandom_range(0, rprt_pkg::MAX_USERS - 1)),
                  rprt_pkg::t_page'($urandom_range(1, 64)), 1'b0, '0);
        end
    endtask

    // Receiver: rotating ready pattern, plus one long hold on request
    initial begin : rank_receiver
        int unsigned beat_clock;
        int unsigned hold_left;
        bit          hold_taken;
        beat_clock = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        rank_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            beat_clock++;
            if (start_long_hold && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rank_if.ready <= 1'b0;
            end else begin
                case ((beat_clock / 97) % 4)
                    0: rank_if.ready <= 1'b1;
                    1: rank_if.ready <= 1'($urandom_range(0, 1));
                    2: rank_if.ready <= (beat_clock % 4 == 0);
                    default: rank_if.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rank_if.valid === 1'b1 && rank_if.ready === 1'b1) begin
            if (expected_ranks.size() == 0) begin
                report_mismatch("rank beat with nothing expected", '0, rank_if.rank_fraction);
            end else begin
                rprt_pkg::t_frac want;
                want = expected_ranks.pop_front();
                ranks_checked++;
                if (rank_if.rank_fraction !== want)
                    report_mismatch("rank_fraction", want, rank_if.rank_fraction);
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int  counted;
        int  burst_left;
        bit  counts;
        bit  hold_done;
        bit  drain_done;
        counted    = 0;
        burst_left = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        mismatches = 0;
        updates_sent  = 0;
        queries_sent  = 0;
        regressions   = 0;
        ranks_checked = 0;
        active_count  = '0;
        start_long_hold = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            reader_pool[i] = rprt_pkg::t_user'($urandom_range(0, rprt_pkg::MAX_USERS - 1));

        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.command    <= rprt_pkg::CMD_UPDATE;
        cmd_if.user_id    <= '0;
        cmd_if.page_count <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            offer(DIRECTED_STEPS[i].command, DIRECTED_STEPS[i].user, DIRECTED_STEPS[i].pages,
                  DIRECTED_STEPS[i].fixed, DIRECTED_STEPS[i].fixed_rank);
            if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 5));
        end

        // Random bursts
        while (counted < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 10));
            end
            random_beat(counts);
            burst_left--;
            if (counts) counted++;

            // Receiver holds off while queries keep coming, so the block backs up
            if (counted >= HOLD_AT_ITEM && !hold_done) begin
                hold_done = 1'b1;
                start_long_hold = 1'b1;
                repeat (12) begin
                    offer(rprt_pkg::CMD_QUERY, reader_pool[$urandom_range(0, POOL_SIZE - 1)],
                          '0, 1'b0, '0);
                    counted++;
                end
            end

            // Sender stands back until every rank has come out
            if (counted >= DRAIN_AT_ITEM && !drain_done) begin
                drain_done = 1'b1;
                wait_for_ranks();
            end
        end

        wait_for_ranks();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d updates (%0d lowering a count) and %0d queries; %0d ranks compared",
                 updates_sent, regressions, queries_sent, ranks_checked);
        $display("Active readers at the end: %0d, with one long receiver hold and one drain",
                 active_count);
        if (mismatches == 0 && expected_ranks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
